// ===== hdl/bsst_pkg.sv =====
// ----------------------------------------------------------------------------
// bsst_pkg
// Shared types for the sorted-table binary search block: item function
// codes, controller states and result flags.
// ----------------------------------------------------------------------------
package bsst_pkg;

  // Function code carried in the input tuser
  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_CMP  = 2'd2,
    ST_DONE = 2'd3
  } state_e;

  // Result flags; found in the low bit
  typedef struct packed {
    logic overflow;
    logic found;
  } flags_t;

endpackage

// ===== hdl/bsst_mem.sv =====
// ----------------------------------------------------------------------------
// bsst_mem
// Table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsst_mem #(
  parameter int Depth = 128,
  parameter int Width = 32,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bsst_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsst_ctrl
// Item sequencer: appends, clears, and runs the binary search over the
// table memory, each probe an address issue state and then a compare state.
// ----------------------------------------------------------------------------
module bsst_ctrl #(
  parameter int Depth = 128,
  parameter int Width = 32,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                desc_i,
  // input item
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_func_i,
  input  logic [Width-1:0]    in_value_i,
  // table memory
  output logic                mem_we_o,
  output logic [AddrW-1:0]    mem_waddr_o,
  output logic [Width-1:0]    mem_wdata_o,
  output logic [AddrW-1:0]    mem_raddr_o,
  input  logic [Width-1:0]    mem_rdata_i,
  // result item
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output bsst_pkg::flags_t    res_flags_o,
  output logic [AddrW-1:0]    res_pos_o
);

  localparam int CntW = AddrW + 1;
  localparam logic [CntW-1:0] DepthC = CntW'(Depth);

  bsst_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  lo_q, lo_d;     // first candidate
  logic [CntW-1:0]  hi_q, hi_d;     // one past last candidate
  logic [AddrW-1:0] mid_q, mid_d;
  logic [Width-1:0] key_q, key_d;
  bsst_pkg::flags_t flags_q, flags_d;
  logic [AddrW-1:0] pos_q, pos_d;

  logic [CntW:0]    mid_sum;
  logic [AddrW-1:0] mid_calc;
  logic             go_left;

  // middle = (lo + hi - 1) / 2, only used while lo < hi
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} - {{CntW{1'b0}}, 1'b1};
  assign mid_calc = mid_sum[AddrW:1];

  // Direction of the next step when the probe misses
  assign go_left = desc_i ? ($signed(key_q) > $signed(mem_rdata_i))
                          : ($signed(key_q) < $signed(mem_rdata_i));

  // State and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsst_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    key_q   <= key_d;
    flags_q <= flags_d;
    pos_q   <= pos_d;
  end

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    key_d       = key_q;
    flags_d     = flags_q;
    pos_d       = pos_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = count_q[AddrW-1:0];
    mem_wdata_o = in_value_i;
    mem_raddr_o = mid_calc;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      bsst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d   = in_value_i;
          flags_d = '0;
          pos_d   = '0;
          state_d = bsst_pkg::ST_DONE;
          case (bsst_pkg::func_e'(in_func_i))
            bsst_pkg::FUNC_APPEND: begin
              if (count_q == DepthC) begin
                flags_d.overflow = 1'b1;
              end else begin
                mem_we_o = 1'b1;
                pos_d    = count_q[AddrW-1:0];
                count_d  = count_q + 1'b1;
              end
            end
            bsst_pkg::FUNC_SEARCH: begin
              lo_d = '0;
              hi_d = count_q;
              if (count_q != '0) begin
                state_d = bsst_pkg::ST_READ;
              end
            end
            bsst_pkg::FUNC_CLEAR: begin
              count_d = '0;
            end
            default: begin
              // unused code: no change, zero result
            end
          endcase
        end
      end

      // Issue the probe address
      bsst_pkg::ST_READ: begin
        mid_d   = mid_calc;
        state_d = bsst_pkg::ST_CMP;
      end

      // Compare probe with key and narrow the range
      bsst_pkg::ST_CMP: begin
        if (mem_rdata_i == key_q) begin
          flags_d.found = 1'b1;
          pos_d         = mid_q;
          state_d       = bsst_pkg::ST_DONE;
        end else begin
          if (go_left) begin
            hi_d = {1'b0, mid_q};
          end else begin
            lo_d = {1'b0, mid_q} + 1'b1;
          end
          state_d = (lo_d < hi_d) ? bsst_pkg::ST_READ : bsst_pkg::ST_DONE;
        end
      end

      // Hand the result to the output register
      bsst_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = bsst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bsst_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_flags_o = flags_q;
  assign res_pos_o   = pos_q;

endmodule

// ===== hdl/binary_search_sorted_table.sv =====
// ----------------------------------------------------------------------------
// binary_search_sorted_table
// Sequence: append, clear and unused codes go from accept to the done state
//   and then the output register; a search first runs P memory probes
//   (P <= log2(TABLE_DEPTH) + 1), each an address issue and then a compare.
// Throughput: one item at a time; the next item is taken once the result
//   moves to the output register, which can hold while the next item runs.
// Reset clears the entry count and the order bit; table words are not cleared.
// ----------------------------------------------------------------------------
module binary_search_sorted_table #(
  parameter int  TABLE_DEPTH = 128,
  parameter int  WORD_WIDTH  = 32,
  localparam int AddrW       = $clog2(TABLE_DEPTH),
  localparam int DataW       = ((WORD_WIDTH + 7) / 8) * 8,
  localparam int PosDataW    = ((AddrW + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,     // descending_order
  // input items
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [DataW-1:0]      s_axis_tdata_i,  // value
  input  logic [1:0]            s_axis_tuser_i,  // func
  // result items
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [PosDataW-1:0]   m_axis_tdata_o,  // position
  output logic [1:0]            m_axis_tuser_o   // found, overflow
);

  logic                   desc_q;
  logic                   mem_we;
  logic [AddrW-1:0]       mem_waddr;
  logic [WORD_WIDTH-1:0]  mem_wdata;
  logic [AddrW-1:0]       mem_raddr;
  logic [WORD_WIDTH-1:0]  mem_rdata;
  logic                   res_valid;
  logic                   res_ready;
  bsst_pkg::flags_t       res_flags;
  logic [AddrW-1:0]       res_pos;

  logic                   out_valid_q;
  bsst_pkg::flags_t       out_flags_q;
  logic [AddrW-1:0]       out_pos_q;

  // Order register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
    end else if (cfg_we_i) begin
      desc_q <= cfg_wdata_i;
    end
  end

  bsst_mem #(
    .Depth (TABLE_DEPTH),
    .Width (WORD_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bsst_ctrl #(
    .Depth (TABLE_DEPTH),
    .Width (WORD_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (desc_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_func_i   (s_axis_tuser_i),
    .in_value_i  (s_axis_tdata_i[WORD_WIDTH-1:0]),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_flags_o (res_flags),
    .res_pos_o   (res_pos)
  );

  // Output register
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_flags_q <= res_flags;
      out_pos_q   <= res_pos;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = PosDataW'(out_pos_q);
  assign m_axis_tuser_o  = {out_flags_q.overflow, out_flags_q.found};

endmodule
